[rtl/core/mlp_pkg.sv]
`timescale 1ns / 1ps
package mlp_pkg;
  localparam int MaxNeurons = 16;
  localparam int MaxStages  = 4;
  localparam int FracBits   = 12;
  localparam int ValW       = 16;
  localparam int ActW       = 13;

  localparam logic [1:0] ReqWeight = 2'd0;
  localparam logic [1:0] ReqBias   = 2'd1;
  localparam logic [1:0] ReqInput  = 2'd2;

  localparam logic [2:0] CfgLayerCount = 3'd0;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  stage;
    logic [3:0]  row;
    logic [3:0]  column;
    logic [15:0] value;
    logic        last_element;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  neuron_index;
    logic [12:0] activation;
    logic        last_result;
  } out_word_t;

  // PLAN sigmoid, input Q4.12 signed, output Q1.12 unsigned
  function automatic logic [12:0] plan_sigmoid(input logic signed [15:0] x);
    logic [16:0] ax;
    logic [12:0] y;
    ax = x[15] ? 17'(-$signed({x[15], x})) : {1'b0, x};
    if (ax >= 17'(5 << FracBits)) y = 13'(1 << FracBits);
    else if (ax >= 17'((19 << FracBits) / 8)) y = 13'((ax >> 5) + ((27 << FracBits) / 32));
    else if (ax >= 17'(1 << FracBits)) y = 13'((ax >> 3) + ((5 << FracBits) / 8));
    else y = 13'((ax >> 2) + ((1 << FracBits) / 2));
    return x[15] ? 13'((1 << FracBits) - y) : y;
  endfunction
endpackage

[rtl/core/mlp_if.sv]
`timescale 1ns / 1ps
interface mlp_in_if;
  logic               valid;
  logic               ready;
  mlp_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mlp_out_if;
  logic               valid;
  logic               ready;
  mlp_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/mlp_sigmoid_inference.sv]
`timescale 1ns / 1ps
// Channel | dir | word
// in_if   | in  | req_type, stage, row, column, value, last_element
// out_if  | out | neuron_index, activation, last_result
// Load words are taken while idle. A pass runs each stage as a stream of the
// source activations down the row of neuron cells: the word for column c
// enters at the head of the chain and moves on through the register in each cell.
// Results leave one per cycle through the output register while out_if is
// ready; the input is held off from the pass until the last result is loaded.
// Reset clears control, configuration and accumulators only.
module mlp_sigmoid_inference (
  input  logic        clk_i,
  input  logic        rst_ni,
  mlp_in_if.sink      in_if,
  mlp_out_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [4:0]  cfg_data_i
);
  localparam int MaxNeurons = mlp_pkg::MaxNeurons;
  localparam int MaxStages  = mlp_pkg::MaxStages;
  localparam int FracBits   = mlp_pkg::FracBits;
  localparam int SW = (MaxStages > 1) ? $clog2(MaxStages) : 1;
  localparam int CW = (MaxNeurons > 1) ? $clog2(MaxNeurons) : 1;
  localparam int TW = $clog2(2*MaxNeurons + 4);

  typedef enum logic [1:0] {IDLE, RUN, DRAIN, EMIT} state_e;

  // configuration registers
  logic [2:0] lc_q;
  logic [4:0] size_q [5];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q <= 3'd3;
      for (int k = 0; k < 5; k++) size_q[k] <= 5'd16;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == mlp_pkg::CfgLayerCount) lc_q <= cfg_data_i[2:0];
      else if (cfg_idx_i <= 3'd5) size_q[cfg_idx_i - 3'd1] <= cfg_data_i;
    end
  end

  function automatic logic [CW:0] eff(input logic [4:0] s);
    if (s == 5'd0) return (CW+1)'(1);
    if (32'(s) > MaxNeurons) return (CW+1)'(MaxNeurons);
    return (CW+1)'(s);
  endfunction

  logic [2:0] stages;
  always_comb begin
    logic [2:0] lc;
    lc = lc_q;
    if (lc < 3'd2) lc = 3'd2;
    if (lc > 3'd5) lc = 3'd5;
    if (32'(lc) > MaxStages + 1) lc = 3'(MaxStages + 1);
    stages = lc - 3'd1;
  end

  // activation banks: each entry read at its own place when streamed
  logic signed [15:0] abuf_q [2][MaxNeurons];
  logic               src_q;

  state_e      state_q;
  logic [2:0]  stg_q;
  logic [TW-1:0] t_q;
  logic [CW:0] n_in, n_out;
  logic [CW:0] emit_q;
  logic        ovalid_q;
  mlp_pkg::out_word_t odata_q;

  assign n_in  = eff(size_q[stg_q]);
  assign n_out = eff(size_q[stg_q + 3'd1]);

  mlp_pkg::in_word_t iw;
  assign iw = in_if.data;
  logic acc_in;
  assign in_if.ready = (state_q == IDLE);
  assign acc_in = in_if.valid && in_if.ready;

  logic wr_w, wr_b;
  assign wr_w = acc_in && iw.req_type == mlp_pkg::ReqWeight && 32'(iw.stage) < MaxStages
                && 32'(iw.row) < MaxNeurons && 32'(iw.column) < MaxNeurons;
  assign wr_b = acc_in && iw.req_type == mlp_pkg::ReqBias && 32'(iw.stage) < MaxStages
                && 32'(iw.row) < MaxNeurons;

  // head of the chain: source column c injected while t_q equals c
  logic signed [15:0] chain [MaxNeurons+1];
  logic [12:0]        sig [MaxNeurons];
  logic [CW-1:0]      col_head;
  assign col_head = t_q[CW-1:0];
  assign chain[0] = (state_q == RUN && {1'b0, t_q} < (TW+1)'(n_in))
                    ? abuf_q[src_q][col_head] : '0;

  // cell r fetches the weight of column t-r and accumulates column t-r-1
  for (genvar r = 0; r < MaxNeurons; r++) begin : g_cell
    logic [TW:0] rel;
    logic        mac, clr;
    assign rel = {1'b0, t_q} - (TW+1)'(r);
    assign clr = (state_q == IDLE) || (state_q == DRAIN);
    assign mac = (state_q == RUN) && (t_q >= TW'(r + 1))
                 && (rel - (TW+1)'(1) < (TW+1)'(n_in));
    mlp_cell #(.MaxNeurons(MaxNeurons), .MaxStages(MaxStages), .FracBits(FracBits)) u_cell (
      .clk_i, .rst_ni,
      .wr_w_i(wr_w && iw.row == CW'(r)), .wr_b_i(wr_b && iw.row == CW'(r)),
      .wr_stage_i(iw.stage[SW-1:0]), .wr_col_i(iw.column[CW-1:0]),
      .wr_val_i(iw.value), .stage_i(stg_q[SW-1:0]),
      .clear_i(clr), .mac_i(mac), .col_i(CW'(rel)),
      .act_i(chain[r]), .act_o(chain[r+1]), .sig_o(sig[r])
    );
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= IDLE;
      stg_q    <= '0;
      t_q      <= '0;
      src_q    <= 1'b0;
      emit_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (out_if.ready && state_q != EMIT) ovalid_q <= 1'b0;
      case (state_q)
        IDLE: begin
          if (acc_in && iw.req_type == mlp_pkg::ReqInput) begin
            if (32'(iw.row) < MaxNeurons) abuf_q[0][iw.row[CW-1:0]] <= iw.value;
            if (iw.last_element) begin
              state_q <= DRAIN;
              stg_q   <= '0;
              src_q   <= 1'b0;
            end
          end
        end
        DRAIN: begin
          state_q <= RUN;
          t_q     <= '0;
        end
        RUN: begin
          t_q <= t_q + 1'b1;
          if ({1'b0, t_q} == (TW+1)'(n_in) + (TW+1)'(MaxNeurons)) begin
            for (int r = 0; r < MaxNeurons; r++)
              if (r < 32'(n_out)) abuf_q[~src_q][r] <= 16'(sig[r]);
            src_q <= ~src_q;
            if (stg_q + 3'd1 == stages) begin
              state_q <= EMIT;
              emit_q  <= '0;
            end else begin
              stg_q   <= stg_q + 3'd1;
              state_q <= DRAIN;
            end
          end
        end
        EMIT: begin
          if (!ovalid_q || out_if.ready) begin
            ovalid_q <= 1'b1;
            odata_q.neuron_index <= 4'(emit_q);
            odata_q.activation   <= abuf_q[src_q][emit_q[CW-1:0]][12:0];
            odata_q.last_result  <= (emit_q + 1'b1 == n_out);
            emit_q <= emit_q + 1'b1;
            if (emit_q + 1'b1 == n_out) state_q <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign out_if.valid = ovalid_q;
  assign out_if.data  = odata_q;
endmodule

[rtl/core/mlp_cell.sv]
`timescale 1ns / 1ps
// One neuron: holds its weights and bias for every stage, one MAC per cycle
// on the activation word streaming past, and passes that word on.
// The weight read is registered, so the MAC for a word runs in the cycle after
// the word reaches the cell, on the copy held in act_o.
module mlp_cell #(
  parameter int MaxNeurons = mlp_pkg::MaxNeurons,
  parameter int MaxStages  = mlp_pkg::MaxStages,
  parameter int FracBits   = mlp_pkg::FracBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_w_i,
  input  logic                          wr_b_i,
  input  logic [$clog2(MaxStages)-1:0]  wr_stage_i,
  input  logic [$clog2(MaxNeurons)-1:0] wr_col_i,
  input  logic signed [15:0]            wr_val_i,
  input  logic [$clog2(MaxStages)-1:0]  stage_i,
  input  logic                          clear_i,
  input  logic                          mac_i,
  input  logic [$clog2(MaxNeurons)-1:0] col_i,
  input  logic signed [15:0]            act_i,
  output logic signed [15:0]            act_o,
  output logic [12:0]                   sig_o
);
  logic signed [15:0] wmem [MaxStages*MaxNeurons];
  logic signed [15:0] bias_q [MaxStages];
  logic signed [15:0] w_q;
  logic signed [39:0] acc_q, acc_d;
  logic signed [31:0] prod;
  logic signed [39:0] sum;
  logic signed [15:0] sat;

  // weight store, written by load words; weight for the arriving word
  always_ff @(posedge clk_i) begin
    if (wr_w_i) wmem[{wr_stage_i, wr_col_i}] <= wr_val_i;
    if (wr_b_i) bias_q[wr_stage_i] <= wr_val_i;
    w_q <= wmem[{stage_i, col_i}];
  end

  // pass activation to the neighbor
  always_ff @(posedge clk_i) begin
    act_o <= act_i;
  end

  assign prod = w_q * act_o;

  always_comb begin
    acc_d = acc_q;
    if (clear_i) acc_d = 40'(bias_q[stage_i]);
    else if (mac_i) acc_d = acc_q + 40'(prod >>> FracBits);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // saturate to Q4.12 and squash
  always_comb begin
    sum = acc_q;
    if (sum > 40'sd32767) sat = 16'sh7fff;
    else if (sum < -40'sd32768) sat = 16'sh8000;
    else sat = sum[15:0];
    sig_o = mlp_pkg::plan_sigmoid(sat);
  end
endmodule
